>>> rtl/mckd_pkg.sv
// ----------------------------------------------------------------------------
// mckd_pkg: shared types and constants for the multi-click key detector
// Holds the state encoding, event codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package mckd_pkg;

  localparam int unsigned DebW  = 8;
  localparam int unsigned WinW  = 16;
  localparam int unsigned LongW = 16;
  localparam int unsigned CntW  = 16;
  localparam int unsigned CfgDW = 16;
  localparam int unsigned CfgIW = 2;
  localparam int unsigned EvW   = 3;

  // Configuration register indexes
  localparam logic [CfgIW-1:0] RegDebounce = 2'd0;
  localparam logic [CfgIW-1:0] RegWindow   = 2'd1;
  localparam logic [CfgIW-1:0] RegLong     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [DebW-1:0]  DebReset  = 8'd2;
  localparam logic [WinW-1:0]  WinReset  = 16'd30;
  localparam logic [LongW-1:0] LongReset = 16'd120;

  typedef enum logic [3:0] {
    ST_IDLE         = 4'd0,
    ST_DEBOUNCE1    = 4'd1,
    ST_PRESSED1     = 4'd2,
    ST_WAIT2        = 4'd3,
    ST_DEBOUNCE2    = 4'd4,
    ST_PRESSED2     = 4'd5,
    ST_WAIT3        = 4'd6,
    ST_DEBOUNCE3    = 4'd7,
    ST_WAIT_RELEASE = 4'd8
  } state_t;

  typedef enum logic [EvW-1:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_LONG   = 3'd4
  } event_t;

endpackage

>>> rtl/multi_click_key_detector.sv
// ----------------------------------------------------------------------------
// multi_click_key_detector
// Debounces sampled key levels and reports single, double and triple clicks
// and long presses, one event code per scan tick.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | key_down (1 bit)
//  out     | output    | out_valid/out_stall| event_code (3 bit)
//  cfg     | input     | cfg_we             | cfg_index (2 bit), cfg_data (16 bit)
//
//  One tick per cycle unless the result is stalled: a tick is registered on
//  entry, passes through the state machine and lands in the result register.
//  Reset empties both stages and returns the machine to idle with default
//  thresholds. A stalled result holds the input stage; a new tick is still
//  taken while the input stage is empty.
//
module multi_click_key_detector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               key_down,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mckd_pkg::EvW-1:0]           event_code,
  input  logic                               cfg_we,
  input  logic [mckd_pkg::CfgIW-1:0]         cfg_index,
  input  logic [mckd_pkg::CfgDW-1:0]         cfg_data
);

  // Configuration registers
  logic [mckd_pkg::DebW-1:0]  debounce_ticks;
  logic [mckd_pkg::WinW-1:0]  click_window_ticks;
  logic [mckd_pkg::LongW-1:0] long_press_ticks;

  // Input stage
  logic s1_valid;
  logic s1_key;

  // Machine state
  mckd_pkg::state_t          fsm_state, fsm_state_next;
  logic [mckd_pkg::CntW-1:0] press_count, press_count_next;
  logic [mckd_pkg::CntW-1:0] window_count, window_count_next;
  mckd_pkg::event_t          event_next;

  logic                      advance;
  logic [mckd_pkg::CntW-1:0] press_inc;
  logic [mckd_pkg::CntW-1:0] window_inc;
  logic                      deb_hit;
  logic                      long_hit;
  logic                      win_hit;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= mckd_pkg::DebReset;
      click_window_ticks <= mckd_pkg::WinReset;
      long_press_ticks   <= mckd_pkg::LongReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mckd_pkg::RegDebounce: debounce_ticks     <= cfg_data[mckd_pkg::DebW-1:0];
        mckd_pkg::RegWindow:   click_window_ticks <= cfg_data[mckd_pkg::WinW-1:0];
        mckd_pkg::RegLong:     long_press_ticks   <= cfg_data[mckd_pkg::LongW-1:0];
        default: ;
      endcase
    end
  end

  // Move the registered tick on when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Capture an incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_key <= key_down;
    end
  end

  // Saturating increments and threshold compares
  assign press_inc  = (&press_count)  ? press_count  : press_count + 1'b1;
  assign window_inc = (&window_count) ? window_count : window_count + 1'b1;
  assign deb_hit    = press_inc >= {{(mckd_pkg::CntW-mckd_pkg::DebW){1'b0}}, debounce_ticks};
  assign long_hit   = press_inc >= long_press_ticks;
  assign win_hit    = window_inc >= click_window_ticks;

  // Next state and counters
  always_comb begin
    fsm_state_next    = fsm_state;
    press_count_next  = press_count;
    window_count_next = window_count;
    unique case (fsm_state)
      mckd_pkg::ST_IDLE: begin
        if (s1_key) begin
          fsm_state_next   = mckd_pkg::ST_DEBOUNCE1;
          press_count_next = '0;
        end
      end
      mckd_pkg::ST_DEBOUNCE1, mckd_pkg::ST_DEBOUNCE2, mckd_pkg::ST_DEBOUNCE3: begin
        if (s1_key) begin
          press_count_next = press_inc;
          if (deb_hit) begin
            if (fsm_state == mckd_pkg::ST_DEBOUNCE1) begin
              fsm_state_next = mckd_pkg::ST_PRESSED1;
            end else if (fsm_state == mckd_pkg::ST_DEBOUNCE2) begin
              fsm_state_next = mckd_pkg::ST_PRESSED2;
            end else begin
              fsm_state_next = mckd_pkg::ST_WAIT_RELEASE;
            end
          end
        end else begin
          fsm_state_next = mckd_pkg::ST_IDLE;
        end
      end
      mckd_pkg::ST_PRESSED1, mckd_pkg::ST_PRESSED2: begin
        if (s1_key) begin
          press_count_next = press_inc;
          if (long_hit) begin
            fsm_state_next = mckd_pkg::ST_WAIT_RELEASE;
          end
        end else begin
          fsm_state_next    = (fsm_state == mckd_pkg::ST_PRESSED1) ?
                              mckd_pkg::ST_WAIT2 : mckd_pkg::ST_WAIT3;
          window_count_next = '0;
        end
      end
      mckd_pkg::ST_WAIT2, mckd_pkg::ST_WAIT3: begin
        window_count_next = window_inc;
        if (s1_key) begin
          fsm_state_next   = (fsm_state == mckd_pkg::ST_WAIT2) ?
                             mckd_pkg::ST_DEBOUNCE2 : mckd_pkg::ST_DEBOUNCE3;
          press_count_next = '0;
        end else if (win_hit) begin
          fsm_state_next = mckd_pkg::ST_IDLE;
        end
      end
      mckd_pkg::ST_WAIT_RELEASE: begin
        if (!s1_key) begin
          fsm_state_next = mckd_pkg::ST_IDLE;
        end
      end
      default: begin
        fsm_state_next = mckd_pkg::ST_IDLE;
      end
    endcase
  end

  // Event decode
  always_comb begin
    event_next = mckd_pkg::EV_NONE;
    unique case (fsm_state)
      mckd_pkg::ST_DEBOUNCE2: begin
        if (!s1_key) event_next = mckd_pkg::EV_SINGLE;
      end
      mckd_pkg::ST_DEBOUNCE3: begin
        if (!s1_key) begin
          event_next = mckd_pkg::EV_DOUBLE;
        end else if (deb_hit) begin
          event_next = mckd_pkg::EV_TRIPLE;
        end
      end
      mckd_pkg::ST_PRESSED1, mckd_pkg::ST_PRESSED2: begin
        if (s1_key && long_hit) event_next = mckd_pkg::EV_LONG;
      end
      mckd_pkg::ST_WAIT2: begin
        if (!s1_key && win_hit) event_next = mckd_pkg::EV_SINGLE;
      end
      mckd_pkg::ST_WAIT3: begin
        if (!s1_key && win_hit) event_next = mckd_pkg::EV_DOUBLE;
      end
      default: begin
        event_next = mckd_pkg::EV_NONE;
      end
    endcase
  end

  // Advance the machine once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state    <= mckd_pkg::ST_IDLE;
      press_count  <= '0;
      window_count <= '0;
    end else if (advance) begin
      fsm_state    <= fsm_state_next;
      press_count  <= press_count_next;
      window_count <= window_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_code <= event_next;
    end
  end

  // Checks
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && fsm_state == mckd_pkg::ST_IDLE) |=> (out_valid && event_code == mckd_pkg::EV_NONE))
    else $error("idle tick reported an event");

  a_release_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && fsm_state == mckd_pkg::ST_WAIT_RELEASE) |=> (event_code == mckd_pkg::EV_NONE))
    else $error("wait-for-release tick reported an event");

  a_triple_release: assert property (@(posedge clk) disable iff (rst)
    (advance && event_next == mckd_pkg::EV_TRIPLE) |=> (fsm_state == mckd_pkg::ST_WAIT_RELEASE))
    else $error("triple click did not lead to wait for release");

  a_long_release: assert property (@(posedge clk) disable iff (rst)
    (advance && event_next == mckd_pkg::EV_LONG) |=> (fsm_state == mckd_pkg::ST_WAIT_RELEASE))
    else $error("long press did not lead to wait for release");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with an empty input stage");

endmodule
